### rtl/i2cebm_pkg.sv
// Shared types and constants for the I2C EEPROM byte master.
// Holds the bus phase and transfer stage encodings, request codes and register defaults.
// No dependencies.
package i2cebm_pkg;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_START_HI = 5'd1,
        PH_START_LO = 5'd2,
        PH_TX_LO    = 5'd3,
        PH_TX_HI    = 5'd4,
        PH_ACK_LO   = 5'd5,
        PH_ACK_HI   = 5'd6,
        PH_RX_LO    = 5'd7,
        PH_RX_HI    = 5'd8,
        PH_MACK_LO  = 5'd9,
        PH_MACK_HI  = 5'd10,
        PH_STOP_A   = 5'd11,
        PH_STOP_B   = 5'd12,
        PH_STOP_C   = 5'd13
    } phase_t;

    typedef enum logic [1:0] {
        STG_DEV_W = 2'd0,
        STG_WORD  = 2'd1,
        STG_DATA  = 2'd2,
        STG_DEV_R = 2'd3
    } stage_t;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic CFG_DEV_ADDR    = 1'b0;
    localparam logic CFG_HALF_PERIOD = 1'b1;

    localparam logic [6:0]  DEV_ADDR_RST    = 7'h51;
    localparam logic [15:0] HALF_PERIOD_RST = 16'd4;

endpackage

### rtl/i2c_eeprom_byte_master_top.sv
// A result word is registered and valid in the cycle after its input word is accepted.
// Throughput: one input word per cycle; input is taken while the result register
// is empty or being drained in the same cycle.
// Bus timing: every SCL/SDA step lasts half_period_ticks tick words (zero counts as one).
// Reset (rst_n low, asynchronous): sequencer idle (the SCL/SDA outputs are not reset), registers at
// their defaults (device address 0x51, four ticks per step), result register empty.
// Top level of the I2C EEPROM byte master; uses i2cebm_pkg.
module i2c_eeprom_byte_master_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [7:0]  word_addr,
    input  logic [7:0]  write_data,
    input  logic        sda_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        scl_out,
    output logic        sda_out,
    output logic        busy_res,
    output logic        done_res,
    output logic [7:0]  read_data,
    output logic        ack_error,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    i2cebm_pkg::phase_t phase_reg, phase_next;
    i2cebm_pkg::stage_t stage_reg, stage_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] tick_count_reg, tick_count_next;
    logic [7:0]  held_addr_reg, held_addr_next;
    logic [7:0]  held_data_reg, held_data_next;
    logic        is_read_reg, is_read_next;
    logic [7:0]  last_read_reg, last_read_next;
    logic        error_reg, error_next;
    logic [6:0]  dev_addr_reg;
    logic [15:0] half_period_reg;

    logic        out_valid_reg;
    logic        scl_reg, sda_reg, busy_reg, done_reg;
    logic [7:0]  read_data_reg;
    logic        ack_error_reg;

    logic        accept;
    logic        step;
    logic        done_next;
    logic        scl_next, sda_next;
    logic [15:0] hp;
    logic [3:0]  bit_inc;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign hp       = (half_period_reg == 16'd0) ? 16'd1 : half_period_reg;
    assign bit_inc  = bit_count_reg + 4'd1;

    // Next state of the bus sequencer
    always_comb
    begin
        phase_next      = phase_reg;
        stage_next      = stage_reg;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        tick_count_next = tick_count_reg;
        held_addr_next  = held_addr_reg;
        held_data_next  = held_data_reg;
        is_read_next    = is_read_reg;
        last_read_next  = last_read_reg;
        error_next      = error_reg;
        step            = 1'b0;
        done_next       = 1'b0;

        if (accept)
        begin
            case (req_type) inside
                i2cebm_pkg::REQ_WRITE, i2cebm_pkg::REQ_READ:
                begin
                    if (phase_reg == i2cebm_pkg::PH_IDLE)
                    begin
                        held_addr_next  = word_addr;
                        held_data_next  = write_data;
                        is_read_next    = (req_type == i2cebm_pkg::REQ_READ);
                        error_next      = 1'b0;
                        stage_next      = i2cebm_pkg::STG_DEV_W;
                        tick_count_next = 16'd0;
                        shift_next      = {dev_addr_reg, 1'b0};
                        bit_count_next  = 4'd0;
                        phase_next      = i2cebm_pkg::PH_START_HI;
                    end
                end
                i2cebm_pkg::REQ_TICK:
                begin
                    if (phase_reg != i2cebm_pkg::PH_IDLE)
                    begin
                        if ({1'b0, tick_count_reg} + 17'd1 >= {1'b0, hp})
                        begin
                            tick_count_next = 16'd0;
                            step            = 1'b1;
                        end
                        else
                        begin
                            tick_count_next = tick_count_reg + 16'd1;
                        end
                    end
                end
                default: ;
            endcase
        end

        if (step)
        begin
            unique case (phase_reg)
                i2cebm_pkg::PH_START_HI: phase_next = i2cebm_pkg::PH_START_LO;
                i2cebm_pkg::PH_START_LO:
                begin
                    bit_count_next = 4'd0;
                    phase_next     = i2cebm_pkg::PH_TX_LO;
                end
                i2cebm_pkg::PH_TX_LO: phase_next = i2cebm_pkg::PH_TX_HI;
                i2cebm_pkg::PH_TX_HI:
                begin
                    shift_next     = {shift_reg[6:0], 1'b0};
                    bit_count_next = bit_inc;
                    phase_next     = (bit_inc >= 4'd8) ? i2cebm_pkg::PH_ACK_LO
                                                       : i2cebm_pkg::PH_TX_LO;
                end
                i2cebm_pkg::PH_ACK_LO: phase_next = i2cebm_pkg::PH_ACK_HI;
                i2cebm_pkg::PH_ACK_HI:
                begin
                    if (sda_in)
                    begin
                        // no acknowledge: flag it and release the bus
                        error_next = 1'b1;
                        phase_next = i2cebm_pkg::PH_STOP_A;
                    end
                    else
                    begin
                        unique case (stage_reg)
                            i2cebm_pkg::STG_DEV_W:
                            begin
                                stage_next     = i2cebm_pkg::STG_WORD;
                                shift_next     = held_addr_reg;
                                bit_count_next = 4'd0;
                                phase_next     = i2cebm_pkg::PH_TX_LO;
                            end
                            i2cebm_pkg::STG_WORD:
                            begin
                                if (is_read_reg)
                                begin
                                    // repeated start, then address with read bit
                                    stage_next = i2cebm_pkg::STG_DEV_R;
                                    shift_next = {dev_addr_reg, 1'b1};
                                    phase_next = i2cebm_pkg::PH_START_HI;
                                end
                                else
                                begin
                                    stage_next     = i2cebm_pkg::STG_DATA;
                                    shift_next     = held_data_reg;
                                    bit_count_next = 4'd0;
                                    phase_next     = i2cebm_pkg::PH_TX_LO;
                                end
                            end
                            i2cebm_pkg::STG_DEV_R:
                            begin
                                shift_next     = 8'd0;
                                bit_count_next = 4'd0;
                                phase_next     = i2cebm_pkg::PH_RX_LO;
                            end
                            default: phase_next = i2cebm_pkg::PH_STOP_A;
                        endcase
                    end
                end
                i2cebm_pkg::PH_RX_LO: phase_next = i2cebm_pkg::PH_RX_HI;
                i2cebm_pkg::PH_RX_HI:
                begin
                    shift_next     = {shift_reg[6:0], sda_in};
                    bit_count_next = bit_inc;
                    phase_next     = (bit_inc >= 4'd8) ? i2cebm_pkg::PH_MACK_LO
                                                       : i2cebm_pkg::PH_RX_LO;
                end
                i2cebm_pkg::PH_MACK_LO: phase_next = i2cebm_pkg::PH_MACK_HI;
                i2cebm_pkg::PH_MACK_HI:
                begin
                    last_read_next = shift_reg;
                    phase_next     = i2cebm_pkg::PH_STOP_A;
                end
                i2cebm_pkg::PH_STOP_A: phase_next = i2cebm_pkg::PH_STOP_B;
                i2cebm_pkg::PH_STOP_B: phase_next = i2cebm_pkg::PH_STOP_C;
                i2cebm_pkg::PH_STOP_C:
                begin
                    phase_next = i2cebm_pkg::PH_IDLE;
                    done_next  = 1'b1;
                end
                default: phase_next = i2cebm_pkg::PH_IDLE;
            endcase
        end
    end

    // Line levels follow from the phase being entered and the bit at the top of the shifter
    always_comb
    begin
        unique case (phase_next) inside
            i2cebm_pkg::PH_START_LO:
            begin
                scl_next = 1'b1;
                sda_next = 1'b0;
            end
            i2cebm_pkg::PH_TX_LO:
            begin
                scl_next = 1'b0;
                sda_next = shift_next[7];
            end
            i2cebm_pkg::PH_TX_HI:
            begin
                scl_next = 1'b1;
                sda_next = shift_next[7];
            end
            i2cebm_pkg::PH_ACK_LO, i2cebm_pkg::PH_RX_LO, i2cebm_pkg::PH_MACK_LO:
            begin
                scl_next = 1'b0;
                sda_next = 1'b1;
            end
            i2cebm_pkg::PH_STOP_A:
            begin
                scl_next = 1'b0;
                sda_next = 1'b0;
            end
            i2cebm_pkg::PH_STOP_B:
            begin
                scl_next = 1'b1;
                sda_next = 1'b0;
            end
            default:
            begin
                scl_next = 1'b1;
                sda_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= i2cebm_pkg::PH_IDLE;
            stage_reg       <= i2cebm_pkg::STG_DEV_W;
            bit_count_reg   <= 4'd0;
            shift_reg       <= 8'd0;
            tick_count_reg  <= 16'd0;
            held_addr_reg   <= 8'd0;
            held_data_reg   <= 8'd0;
            is_read_reg     <= 1'b0;
            last_read_reg   <= 8'd0;
            error_reg       <= 1'b0;
            dev_addr_reg    <= i2cebm_pkg::DEV_ADDR_RST;
            half_period_reg <= i2cebm_pkg::HALF_PERIOD_RST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            stage_reg      <= stage_next;
            bit_count_reg  <= bit_count_next;
            shift_reg      <= shift_next;
            tick_count_reg <= tick_count_next;
            held_addr_reg  <= held_addr_next;
            held_data_reg  <= held_data_next;
            is_read_reg    <= is_read_next;
            last_read_reg  <= last_read_next;
            error_reg      <= error_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    i2cebm_pkg::CFG_DEV_ADDR:    dev_addr_reg    <= cfg_data[6:0];
                    i2cebm_pkg::CFG_HALF_PERIOD: half_period_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result word: payload only, loaded on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            busy_reg      <= (phase_next != i2cebm_pkg::PH_IDLE);
            done_reg      <= done_next;
            read_data_reg <= last_read_next;
            ack_error_reg <= error_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign scl_out   = scl_reg;
    assign sda_out   = sda_reg;
    assign busy_res  = busy_reg;
    assign done_res  = done_reg;
    assign read_data = read_data_reg;
    assign ack_error = ack_error_reg;

    // A finished transaction never reports busy
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> !busy_res)
        else $error("done reported while busy");

    // The bit counter never passes one byte
    a_bit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg <= 4'd8)
        else $error("bit counter out of range");

    // An accepted word always yields a result in the next cycle
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted word produced no result");

    // Idle bus keeps the tick counter cleared
    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == i2cebm_pkg::PH_IDLE) |-> (tick_count_reg == 16'd0))
        else $error("tick counter running while idle");

endmodule
